[rtl/addressable_led_strip_driver_assert.svh]
// ----------------------------------------------------------------------------
// LED strip driver assertion macros
// Same-cycle and next-cycle implication checks, gated off during reset.
// ----------------------------------------------------------------------------
`ifndef ADDRESSABLE_LED_STRIP_DRIVER_ASSERT_SVH
`define ADDRESSABLE_LED_STRIP_DRIVER_ASSERT_SVH

// Antecedent holds -> consequent holds in the same cycle.
`define ALSD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent holds -> consequent holds in the next cycle.
`define ALSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/alsd_pkg.sv]
// ----------------------------------------------------------------------------
// LED strip driver package
// Command codes, register map, state types and pixel packing.
// ----------------------------------------------------------------------------
package alsd_pkg;

	// Commands
	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_START = 2'd1;
	localparam logic [1:0] ACT_TICK  = 2'd2;

	// Register map (word index, byte address 4*index)
	localparam int unsigned ADDR_W = 5;
	localparam logic [2:0] REG_LED_COUNT    = 3'd0;
	localparam logic [2:0] REG_FOUR_BYTE    = 3'd1;
	localparam logic [2:0] REG_SWAP_RG      = 3'd2;
	localparam logic [2:0] REG_BIT_PERIOD   = 3'd3;
	localparam logic [2:0] REG_ZERO_HIGH    = 3'd4;
	localparam logic [2:0] REG_ONE_HIGH     = 3'd5;
	localparam logic [2:0] REG_RESET_PERIOD = 3'd6;

	// Register reset values
	localparam logic [8:0]  RST_LED_COUNT    = 9'd1;
	localparam logic [7:0]  RST_BIT_PERIOD   = 8'd40;
	localparam logic [7:0]  RST_ZERO_HIGH    = 8'd11;
	localparam logic [7:0]  RST_ONE_HIGH     = 8'd26;
	localparam logic [15:0] RST_RESET_PERIOD = 16'd1666;

	// Bits per LED
	localparam logic [5:0] BITS_THREE = 6'd24;
	localparam logic [5:0] BITS_FOUR  = 6'd32;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_SEND = 2'd1,
		PH_GAP  = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		CTRL_CLEAR = 2'd0,
		CTRL_READY = 2'd1,
		CTRL_LOAD  = 2'd2
	} ctrl_state_t;

	// Lay out a color word in send order, first byte on top.
	function automatic logic [31:0] pack_pixel(input logic [31:0] color,
			input logic swap_rg, input logic four_byte);
		logic [31:0] word;
		if (swap_rg) begin
			word = {color[31:24], color[23:16], color[15:8], 8'h00};
		end else begin
			word = {color[23:16], color[31:24], color[15:8], 8'h00};
		end
		if (four_byte) begin
			word[7:0] = color[7:0];
		end
		return word;
	endfunction

endpackage

[rtl/addressable_led_strip_driver.sv]
// ----------------------------------------------------------------------------
// Addressable LED strip driver
// Pixel store plus single-wire bit-slot waveform generator with latch gap.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: present action/position/color with start; a transaction
//   is taken at an edge where start is high and busy is low. Actions are a
//   pixel write, a frame start, or one waveform tick.
//   Every transaction yields exactly one result (line_level, busy_res,
//   start_accepted, frame_done) shown for one cycle with result_valid. The
//   receiver cannot stall; results are never held back.
//   Timing: a plain transaction's result is registered and appears in the
//   cycle after it. A frame start from idle and a tick that ends the last
//   bit of an LED other than the frame's last one read the next pixel from
//   the pixel memory, whose read port is registered: they pass through the
//   load state before the result; all others may follow back to back.
//   Reset: registers take their defaults, the frame state goes idle, and a
//   clearing pass zeroes every pixel memory entry, one entry a cycle, with
//   busy high. The APB port takes writes throughout.
//   Configuration writes are meant for idle periods; register changes
//   mid-frame take effect on the next tick.
// ----------------------------------------------------------------------------
module addressable_led_strip_driver #(
	parameter int MAX_LEDS = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Command channel
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  action,
	input  logic [7:0]                  position,
	input  logic [31:0]                 color,
	// Result channel
	output logic                        result_valid,
	output logic                        line_level,
	output logic                        busy_res,
	output logic                        start_accepted,
	output logic                        frame_done,
	// APB configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [alsd_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import alsd_pkg::*;

	`include "addressable_led_strip_driver_assert.svh"

	// Memory address width and LED index width (index must hold MAX_LEDS).
	localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
	localparam int LW = $clog2(MAX_LEDS + 1);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [8:0]  led_count_q;
	logic        four_byte_q;
	logic        swap_rg_q;
	logic [7:0]  bit_period_q;
	logic [7:0]  zero_high_q;
	logic [7:0]  one_high_q;
	logic [15:0] reset_period_q;

	logic       cfg_we;
	logic [2:0] cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_we  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_count_q    <= RST_LED_COUNT;
			four_byte_q    <= 1'b0;
			swap_rg_q      <= 1'b0;
			bit_period_q   <= RST_BIT_PERIOD;
			zero_high_q    <= RST_ZERO_HIGH;
			one_high_q     <= RST_ONE_HIGH;
			reset_period_q <= RST_RESET_PERIOD;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_LED_COUNT:    led_count_q    <= pwdata[8:0];
				REG_FOUR_BYTE:    four_byte_q    <= pwdata[0];
				REG_SWAP_RG:      swap_rg_q      <= pwdata[0];
				REG_BIT_PERIOD:   bit_period_q   <= pwdata[7:0];
				REG_ZERO_HIGH:    zero_high_q    <= pwdata[7:0];
				REG_ONE_HIGH:     one_high_q     <= pwdata[7:0];
				REG_RESET_PERIOD: reset_period_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Register readback
	always_comb begin
		case (cfg_idx)
			REG_LED_COUNT:    prdata = {23'd0, led_count_q};
			REG_FOUR_BYTE:    prdata = {31'd0, four_byte_q};
			REG_SWAP_RG:      prdata = {31'd0, swap_rg_q};
			REG_BIT_PERIOD:   prdata = {24'd0, bit_period_q};
			REG_ZERO_HIGH:    prdata = {24'd0, zero_high_q};
			REG_ONE_HIGH:     prdata = {24'd0, one_high_q};
			REG_RESET_PERIOD: prdata = {16'd0, reset_period_q};
			default:          prdata = 32'd0;
		endcase
	end

	// ------------------------------------------------------------------
	// Control and frame state
	// ------------------------------------------------------------------
	ctrl_state_t ctrl_q, ctrl_d;
	logic [AW-1:0] clr_addr_q;

	phase_t        phase_q, phase_d;
	logic [LW-1:0] led_index_q, led_index_d;
	logic [4:0]    bit_index_q, bit_index_d;
	logic [15:0]   tick_q, tick_d;
	logic [31:0]   shift_q, shift_d;

	// Result payload and strobe
	logic result_valid_q;
	logic level_q, busy_res_q, accepted_q, done_q;
	logic r_level, r_busy, r_accepted, r_done;

	// Pixel memory ports
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [31:0]   mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [31:0]   rdata_q;

	logic          accept;
	logic          need_load;
	logic          in_range;
	logic [31:0]   pos_wide;
	logic [31:0]   leds_wide;
	logic [LW-1:0] frame_leds;
	logic [LW-1:0] led_next;
	logic [7:0]    high_ticks;
	logic [5:0]    bits_per_led;
	logic [5:0]    bit_inc;

	assign accept = start && (ctrl_q == CTRL_READY);

	// Effective frame length: zero acts as one, saturate at MAX_LEDS.
	always_comb begin
		leds_wide = {23'd0, led_count_q};
		if (leds_wide == 32'd0) begin
			leds_wide = 32'd1;
		end
		if (leds_wide > 32'(MAX_LEDS)) begin
			leds_wide = 32'(MAX_LEDS);
		end
		frame_leds = leds_wide[LW-1:0];
	end

	assign pos_wide     = {24'd0, position};
	assign in_range     = pos_wide < 32'(MAX_LEDS);
	assign led_next     = led_index_q + LW'(1);
	assign high_ticks   = shift_q[31] ? one_high_q : zero_high_q;
	assign bits_per_led = four_byte_q ? BITS_FOUR : BITS_THREE;
	assign bit_inc      = {1'b0, bit_index_q} + 6'd1;

	// Transaction datapath: next frame state, result and memory read address.
	always_comb begin
		phase_d     = phase_q;
		led_index_d = led_index_q;
		bit_index_d = bit_index_q;
		tick_d      = tick_q;
		shift_d     = shift_q;
		need_load   = 1'b0;
		mem_raddr   = '0;
		r_level     = 1'b0;
		r_accepted  = 1'b0;
		r_done      = 1'b0;
		r_busy      = (phase_q != PH_IDLE);
		case (action)
			ACT_START: begin
				if (phase_q == PH_IDLE) begin
					phase_d     = PH_SEND;
					led_index_d = '0;
					bit_index_d = '0;
					tick_d      = '0;
					need_load   = 1'b1;
					r_accepted  = 1'b1;
					r_busy      = 1'b1;
				end
			end
			ACT_TICK: begin
				case (phase_q)
					PH_SEND: begin
						r_level = (tick_q < {8'd0, high_ticks});
						if (tick_q >= {8'd0, bit_period_q}) begin
							tick_d  = '0;
							shift_d = {shift_q[30:0], 1'b0};
							if (bit_inc >= bits_per_led) begin
								bit_index_d = '0;
								if ({1'b0, led_next} >= {1'b0, frame_leds}) begin
									phase_d = PH_GAP;
								end else begin
									led_index_d = led_next;
									mem_raddr   = led_next[AW-1:0];
									need_load   = 1'b1;
								end
							end else begin
								bit_index_d = bit_inc[4:0];
							end
						end else begin
							tick_d = tick_q + 16'd1;
						end
					end
					PH_GAP: begin
						if (tick_q >= reset_period_q) begin
							r_done      = 1'b1;
							phase_d     = PH_IDLE;
							tick_d      = '0;
							led_index_d = '0;
						end else begin
							tick_d = tick_q + 16'd1;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// Sequencer: clearing pass, ready, pixel load.
	always_comb begin
		ctrl_d = ctrl_q;
		busy   = (ctrl_q != CTRL_READY);
		case (ctrl_q)
			CTRL_CLEAR: begin
				if (clr_addr_q == AW'(MAX_LEDS - 1)) begin
					ctrl_d = CTRL_READY;
				end
			end
			CTRL_READY: begin
				if (accept && need_load) begin
					ctrl_d = CTRL_LOAD;
				end
			end
			CTRL_LOAD: ctrl_d = CTRL_READY;
			default:   ctrl_d = CTRL_READY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q     <= CTRL_CLEAR;
			clr_addr_q <= '0;
		end else begin
			ctrl_q <= ctrl_d;
			if (ctrl_q == CTRL_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
		end
	end

	// Frame state: advance on each transaction; take the new pixel word
	// from memory in the load cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			led_index_q <= '0;
			bit_index_q <= '0;
			tick_q      <= '0;
			shift_q     <= '0;
		end else if (ctrl_q == CTRL_LOAD) begin
			shift_q <= rdata_q;
		end else if (accept) begin
			phase_q     <= phase_d;
			led_index_q <= led_index_d;
			bit_index_q <= bit_index_d;
			tick_q      <= tick_d;
			shift_q     <= shift_d;
		end
	end

	// Result strobe: registered; high in the cycle after a plain transaction,
	// or after the load cycle for a transaction that fetched a pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= (accept && !need_load) || (ctrl_q == CTRL_LOAD);
		end
	end

	// Result payload: capture on the transaction, hold through the load.
	always_ff @(posedge clk) begin
		if (accept) begin
			level_q    <= r_level;
			busy_res_q <= r_busy;
			accepted_q <= r_accepted;
			done_q     <= r_done;
		end
	end

	assign result_valid   = result_valid_q;
	assign line_level     = level_q;
	assign busy_res       = busy_res_q;
	assign start_accepted = accepted_q;
	assign frame_done     = done_q;

	// ------------------------------------------------------------------
	// Pixel memory: one write port, one registered read port
	// ------------------------------------------------------------------
	logic [31:0] pixel_mem [0:MAX_LEDS-1];

	always_comb begin
		if (ctrl_q == CTRL_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = accept && (action == ACT_WRITE) && in_range;
			mem_waddr = pos_wide[AW-1:0];
			mem_wdata = pack_pixel(color, swap_rg_q, four_byte_q);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			pixel_mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= pixel_mem[mem_raddr];
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`ALSD_ASSERT_NEXT(a_load_one_cycle, clk, arst_n, ctrl_q == CTRL_LOAD,
		ctrl_q == CTRL_READY, "pixel load held longer than one cycle")
	`ALSD_ASSERT_NEXT(a_accept_answers, clk, arst_n, accept,
		result_valid || ctrl_q == CTRL_LOAD, "transaction produced no result or load")
	`ALSD_ASSERT_IMPLIES(a_done_in_gap, clk, arst_n, result_valid && frame_done,
		busy_res && !line_level, "frame done outside the latch gap")
	`ALSD_ASSERT_IMPLIES(a_level_busy, clk, arst_n, result_valid && line_level,
		busy_res && !start_accepted, "line driven high outside a frame")

endmodule
